// File: src/utf8_to_ucs2_decoder_top_macros.svh
// Assertion macros used by the decoder back end.
// Included by u8u2_back, which checks its own logic; needs nothing else.
`ifndef UTF8_TO_UCS2_DECODER_TOP_MACROS_SVH
`define UTF8_TO_UCS2_DECODER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define U8U2_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define U8U2_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/u8u2_pkg.sv
// Shared types and constants of the UTF-8 to 16-bit code unit decoder.
// No dependencies.
package u8u2_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned UnitW   = 16;
  localparam int unsigned CountW  = 13;
  localparam int unsigned PartW   = 10;
  localparam int unsigned LimitW  = 16;

  // Continuation bytes still expected
  localparam logic [1:0] PendNone = 2'd0;
  localparam logic [1:0] PendOne  = 2'd1;
  localparam logic [1:0] PendTwo  = 2'd2;

  localparam logic [CountW-1:0] LimitReset = 13'd4096;

  // Class of one incoming byte
  typedef enum logic [2:0] {
    KIND_ASCII,
    KIND_CONT,
    KIND_LEAD2,
    KIND_LEAD3,
    KIND_NONE
  } byte_kind_e;

  // One queued transaction between front and back
  typedef struct packed {
    byte_kind_e        kind;
    logic [ByteW-1:0]  data;
    logic              last;
  } q_entry_t;

endpackage

// File: src/u8u2_front.sv
// Front end: accepts input transactions and classifies each byte.
// Depends on u8u2_pkg; feeds u8u2_queue.
module u8u2_front
  import u8u2_pkg::*;
(
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] in_byte_i,
  input  logic             last_byte_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output q_entry_t         q_entry_o
);

  byte_kind_e kind;

  // Classify by leading bits
  always_comb begin
    if (!in_byte_i[7]) begin
      kind = KIND_ASCII;
    end else if (!in_byte_i[6]) begin
      kind = KIND_CONT;
    end else if (!in_byte_i[5]) begin
      kind = KIND_LEAD2;
    end else if (!in_byte_i[4]) begin
      kind = KIND_LEAD3;
    end else begin
      kind = KIND_NONE;
    end
  end

  // Stall while the queue is full
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  assign q_entry_o.kind = kind;
  assign q_entry_o.data = in_byte_i;
  assign q_entry_o.last = last_byte_i;

endmodule

// File: src/u8u2_queue.sv
// Two-entry queue between front and back ends.
// Depends on u8u2_pkg.
module u8u2_queue
  import u8u2_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t push_entry_i,
  output logic     full_o,
  output logic     valid_o,
  input  logic     pop_i,
  output q_entry_t pop_entry_o
);

  q_entry_t   mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o      = (cnt_q == 2'd2);
  assign valid_o     = (cnt_q != 2'd0);
  assign pop_entry_o = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// File: src/u8u2_back.sv
// Back end: sequence state, unit count, limit register and output register.
// Depends on u8u2_pkg and the assertion macro header.
`include "utf8_to_ucs2_decoder_top_macros.svh"
module u8u2_back
  import u8u2_pkg::*;
#(
  parameter int unsigned MAX_UNITS = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_output_limit_i,
  input  logic              q_valid_i,
  input  q_entry_t          q_entry_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              unit_valid_o,
  output logic [UnitW-1:0]  code_unit_o,
  output logic              string_done_o,
  output logic [CountW-1:0] total_units_o
);

  localparam logic [LimitW-1:0] MaxUnitsW = LimitW'(MAX_UNITS);

  logic [CountW-1:0] limit_q;
  logic [1:0]        pend_q, pend_d;
  logic [PartW-1:0]  part_q, part_d;
  logic [CountW-1:0] count_q, count_d, total;
  logic              ovalid_q;
  logic              uvalid_q, uvalid_d;
  logic [UnitW-1:0]  unit_q, unit_d;
  logic              done_q;
  logic [CountW-1:0] total_q;
  logic [LimitW-1:0] limit_eff;
  logic              at_limit;
  logic              pop;

  // Limit in force is the smaller of register and parameter
  assign limit_eff = ({3'b000, limit_q} > MaxUnitsW) ? MaxUnitsW : {3'b000, limit_q};
  assign at_limit  = ({3'b000, count_q} >= limit_eff);

  // Take the next transaction when the output register frees up
  assign pop     = q_valid_i && (!ovalid_q || !out_stall_i);
  assign q_pop_o = pop;

  // Decode one byte
  always_comb begin
    pend_d   = pend_q;
    part_d   = part_q;
    uvalid_d = 1'b0;
    unit_d   = '0;
    if (at_limit) begin
      pend_d = PendNone;
      part_d = '0;
    end else if (pend_q == PendTwo) begin
      part_d = {part_q[3:0], q_entry_i.data[5:0]};
      pend_d = PendOne;
    end else if (pend_q == PendOne) begin
      unit_d   = {part_q, q_entry_i.data[5:0]};
      uvalid_d = 1'b1;
      pend_d   = PendNone;
      part_d   = '0;
    end else begin
      case (q_entry_i.kind)
        KIND_ASCII: begin
          unit_d   = {8'h00, q_entry_i.data};
          uvalid_d = 1'b1;
        end
        KIND_LEAD2: begin
          part_d = {5'b00000, q_entry_i.data[4:0]};
          pend_d = PendOne;
        end
        KIND_LEAD3: begin
          part_d = {6'b000000, q_entry_i.data[3:0]};
          pend_d = PendTwo;
        end
        default: begin
          // stray continuation or long lead: drop
        end
      endcase
    end
    total   = uvalid_d ? (count_q + 13'd1) : count_q;
    count_d = total;
    // Clear string state at end of string
    if (q_entry_i.last) begin
      pend_d  = PendNone;
      part_d  = '0;
      count_d = '0;
    end
  end

  // Control and string state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= LimitReset;
      pend_q   <= PendNone;
      part_q   <= '0;
      count_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_output_limit_i;
      end
      if (pop) begin
        pend_q  <= pend_d;
        part_q  <= part_d;
        count_q <= count_d;
      end
      if (pop) begin
        ovalid_q <= 1'b1;
      end else if (!out_stall_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (pop) begin
      uvalid_q <= uvalid_d;
      unit_q   <= unit_d;
      done_q   <= q_entry_i.last;
      total_q  <= total;
    end
  end

  assign out_valid_o   = ovalid_q;
  assign unit_valid_o  = uvalid_q;
  assign code_unit_o   = unit_q;
  assign string_done_o = done_q;
  assign total_units_o = total_q;

  `U8U2_ASSERT_NOW(a_zero_unit, clk_i, rst_ni, ovalid_q && !uvalid_q,
    unit_q == '0, "code unit set without a valid unit")
  `U8U2_ASSERT_NOW(a_total_nz, clk_i, rst_ni, ovalid_q && uvalid_q,
    total_q != '0, "unit emitted with zero total")
  `U8U2_ASSERT_NEXT(a_end_clear, clk_i, rst_ni, pop && q_entry_i.last,
    (count_q == '0) && (pend_q == PendNone), "string state not cleared at end of string")
  `U8U2_ASSERT_NOW(a_pend_code, clk_i, rst_ni, 1'b1,
    pend_q != 2'd3, "illegal pending count")

endmodule

// File: src/utf8_to_ucs2_decoder_top.sv
// Top level of the UTF-8 to 16-bit code unit decoder.
// Depends on u8u2_pkg, u8u2_front, u8u2_queue and u8u2_back.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one UTF-8 byte per
//   transaction with last_byte_i marking the end of a string. Output channel
//   (out_valid_o / out_stall_i) returns exactly one result per byte: a code
//   unit with unit_valid_o, string_done_o, and the running total_units_o.
//   cfg_we_i writes the per-string output limit; write it only while idle.
// Timing:
//   An input byte is written into the queue, then decoded into the output
//   register. Throughput is one byte per cycle while out_stall_i is low, set by
//   the decode step in the back end whose registered sequence state feeds the next byte.
//   A two-entry queue decouples the front classifier from the back end.
// Reset:
//   rst_ni clears the queue, sequence state, unit count and output valid and
//   sets the output limit to 4096.
// Backpressure:
//   While out_stall_i is high the result holds; the queue then fills and
//   in_stall_o rises once it holds two bytes.
module utf8_to_ucs2_decoder_top
  import u8u2_pkg::*;
#(
  parameter int unsigned MAX_UNITS = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_output_limit_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [ByteW-1:0]  in_byte_i,
  input  logic              last_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              unit_valid_o,
  output logic [UnitW-1:0]  code_unit_o,
  output logic              string_done_o,
  output logic [CountW-1:0] total_units_o
);

  logic     q_full;
  logic     q_push;
  logic     q_valid;
  logic     q_pop;
  q_entry_t push_entry;
  q_entry_t pop_entry;

  // Accept and classify
  u8u2_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .last_byte_i (last_byte_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (push_entry)
  );

  // Decouple front from back
  u8u2_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .valid_o      (q_valid),
    .pop_i        (q_pop),
    .pop_entry_o  (pop_entry)
  );

  // Decode and deliver
  u8u2_back #(
    .MAX_UNITS (MAX_UNITS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_output_limit_i (cfg_output_limit_i),
    .q_valid_i          (q_valid),
    .q_entry_i          (pop_entry),
    .q_pop_o            (q_pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .unit_valid_o       (unit_valid_o),
    .code_unit_o        (code_unit_o),
    .string_done_o      (string_done_o),
    .total_units_o      (total_units_o)
  );

endmodule
